@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the codec RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define VSC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define VSC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/vsc_pkg.sv @@
// Shared types and constants of the varint stream codec.
package vsc_pkg;

  localparam logic       ACT_DECODE = 1'b0;
  localparam logic       ACT_ENCODE = 1'b1;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] MAX_BYTES  = 3'd5;
  localparam logic [2:0] LAST_POS   = 3'd4;

  typedef struct packed {
    logic        is_enc;
    logic [7:0]  data_byte;
    logic [31:0] value;
    logic [2:0]  nbytes;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_ENC
  } back_state_t;

endpackage

@@ rtl/core/vsc_in_if.sv @@
// Input channel: one decode byte or one encode value per transfer.
interface vsc_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         in_byte;
  logic signed [31:0] in_value;

  modport source (output valid, action, in_byte, in_value, input ready);
  modport sink (input valid, action, in_byte, in_value, output ready);
endinterface

@@ rtl/core/vsc_out_if.sv @@
// Result channel: one decoded value, encoded byte or error per transfer.
interface vsc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] out_data;
  logic [7:0]         out_byte;
  logic [2:0]         byte_count;
  logic               last;

  modport source (output valid, kind, out_data, out_byte, byte_count, last, input ready);
  modport sink (input valid, kind, out_data, out_byte, byte_count, last, output ready);
endinterface

@@ rtl/core/vsc_front.sv @@
// Front end: takes input transfers, sizes encode values, pushes to the queue.
module vsc_front
  import vsc_pkg::*;
(
  vsc_in_if.sink    in_ch,
  input  q_stat_t   q_stat,
  output logic      push,
  output q_entry_t  push_entry
);

  logic [31:0] u;
  logic [2:0]  nbytes;

  assign u = unsigned'(in_ch.in_value);

  always_comb begin
    if (u[31:28] != '0) begin
      nbytes = 3'd5;
    end else if (u[27:21] != '0) begin
      nbytes = 3'd4;
    end else if (u[20:14] != '0) begin
      nbytes = 3'd3;
    end else if (u[13:7] != '0) begin
      nbytes = 3'd2;
    end else begin
      nbytes = 3'd1;
    end
  end

  assign in_ch.ready          = !q_stat.full;
  assign push                 = in_ch.valid && !q_stat.full;
  assign push_entry.is_enc    = (in_ch.action == ACT_ENCODE);
  assign push_entry.data_byte = in_ch.in_byte;
  assign push_entry.value     = u;
  assign push_entry.nbytes    = nbytes;

endmodule

@@ rtl/core/vsc_queue.sv @@
// Small FIFO between the front end and the back end.
module vsc_queue
  import vsc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head,
  output q_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_valid = !stat.empty;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/vsc_back.sv @@
// Back end: decode accumulator, encode byte sequencer and output register.
module vsc_back
  import vsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         head_valid,
  input  q_entry_t     head,
  output logic         pop,
  vsc_out_if.source    out_ch
);

  back_state_t state_r, state_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [2:0]  total_r, total_nxt;

  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] value_r, value_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  count_r, count_nxt;
  logic        last_r, last_nxt;

  logic        can_emit;
  logic [31:0] part;
  logic [31:0] acc_or;
  logic        more;

  function automatic logic [31:0] place(input logic [6:0] d, input logic [2:0] p);
    logic [31:0] r;
    r = '0;
    unique case (p)
      3'd0:    r = {25'd0, d};
      3'd1:    r = {18'd0, d, 7'd0};
      3'd2:    r = {11'd0, d, 14'd0};
      3'd3:    r = {4'd0, d, 21'd0};
      default: r = {d[3:0], 28'd0};
    endcase
    return r;
  endfunction

  assign can_emit = !valid_r || out_ch.ready;
  assign part     = place(head.data_byte[6:0], seen_r);
  assign acc_or   = acc_r | part;
  assign more     = (head.nbytes != 3'd1);

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    shift_nxt = shift_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    valid_nxt = valid_r && !out_ch.ready;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    byte_nxt  = byte_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (head_valid && can_emit) begin
          pop = 1'b1;
          if (head.is_enc) begin
            valid_nxt = 1'b1;
            kind_nxt  = KIND_BYTE;
            value_nxt = '0;
            byte_nxt  = {more, head.value[6:0]};
            count_nxt = 3'd1;
            last_nxt  = !more;
            shift_nxt = head.value >> 7;
            pos_nxt   = 3'd2;
            total_nxt = head.nbytes;
            if (more) begin
              state_nxt = BK_ENC;
            end
          end else if (!head.data_byte[7]) begin
            valid_nxt = 1'b1;
            kind_nxt  = KIND_VALUE;
            value_nxt = acc_or;
            byte_nxt  = '0;
            count_nxt = seen_r + 1'b1;
            last_nxt  = 1'b1;
            acc_nxt   = '0;
            seen_nxt  = '0;
          end else if (seen_r == LAST_POS) begin
            valid_nxt = 1'b1;
            kind_nxt  = KIND_ERROR;
            value_nxt = '0;
            byte_nxt  = '0;
            count_nxt = MAX_BYTES;
            last_nxt  = 1'b1;
            acc_nxt   = '0;
            seen_nxt  = '0;
          end else begin
            acc_nxt  = acc_or;
            seen_nxt = seen_r + 1'b1;
          end
        end
      end
      BK_ENC: begin
        if (can_emit) begin
          valid_nxt = 1'b1;
          kind_nxt  = KIND_BYTE;
          value_nxt = '0;
          byte_nxt  = {(pos_r != total_r), shift_r[6:0]};
          count_nxt = pos_r;
          last_nxt  = (pos_r == total_r);
          shift_nxt = shift_r >> 7;
          pos_nxt   = pos_r + 1'b1;
          if (pos_r == total_r) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      acc_r   <= '0;
      seen_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    pos_r   <= pos_nxt;
    total_r <= total_nxt;
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    byte_r  <= byte_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.out_data   = signed'(value_r);
  assign out_ch.out_byte   = byte_r;
  assign out_ch.byte_count = count_r;
  assign out_ch.last       = last_r;

endmodule

@@ rtl/core/varint_stream_codec.sv @@
// Top level of the LEB128 32-bit varint stream codec.
//
//  channel  | dir | payload                                        | transfer
//  ---------+-----+------------------------------------------------+-----------------
//  in_ch    | in  | action, in_byte, in_value                      | valid & ready
//  out_ch   | out | kind, out_data, out_byte, byte_count, last     | valid & ready
//
// A decode byte is handled by the back end as it is popped; an encode value holds the back end
// until all of its 1 to 5 stream bytes are out, paced by the back end's byte sequencer.
// A first result passes from the input transfer through the queue, then the output register.
// Synchronous reset clears the queue, decoder state and output valid.
// Holding out_ch.ready low stalls the back end; in_ch.ready drops once the queue fills.
`include "assert_macros.svh"

module varint_stream_codec
  import vsc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  vsc_in_if.sink     in_ch,
  vsc_out_if.source  out_ch
);

  logic     push, pop, head_valid;
  q_entry_t push_entry, head;
  q_stat_t  q_stat;
  logic     res_enc, res_dec;

  vsc_front u_front (
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  vsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .stat       (q_stat)
  );

  vsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  assign res_enc = out_ch.valid && (out_ch.kind == KIND_BYTE);
  assign res_dec = out_ch.valid && (out_ch.kind != KIND_BYTE);

  `VSC_ASSERT_ALWAYS(a_q_not_both, !(q_stat.full && q_stat.empty), "queue full and empty")
  `VSC_ASSERT_IMPLY(a_pop_has_head, pop, head_valid, "pop from empty queue")
  `VSC_ASSERT_IMPLY(a_enc_more_bit, res_enc, out_ch.out_byte[7] == !out_ch.last, "bad more bit")
  `VSC_ASSERT_IMPLY(a_dec_last, res_dec, out_ch.last && out_ch.out_byte == '0, "decode not last")

endmodule
